/* hw/rtl/fsc_pkg.sv */
// Shared constants and types for the frame stream checker.
`default_nettype none

package fsc_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_FRAME_BYTES = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_WORD       = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [31:0] MAX_FRAME_BYTES_RST = 32'd265000;
  localparam logic [31:0] SYNC_WORD_RST       = 32'h708b309e;

  // Header length in words (legal range 2 to 4).
  localparam int unsigned HEADER_WORDS_DEF = 4;

  // Header word index width, enough for four header words.
  localparam int unsigned HdrIdxW = 2;

  // Words still to skip in the payload.
  localparam int unsigned WordsLeftW = 30;

  // One result item.
  typedef struct packed {
    logic        frame_done;
    logic        seq_error;
    logic        size_error;
    logic        hunting;
    logic [31:0] frame_count;
    logic [31:0] seq_error_count;
    logic [31:0] size_error_count;
  } fsc_result_t;

endpackage

`default_nettype wire

/* hw/rtl/fsc_core.sv */
// Frame tracking state and per-word step logic of the frame stream checker.
`default_nettype none

module fsc_core
  import fsc_pkg::*;
#(
  parameter int unsigned HEADER_WORDS = HEADER_WORDS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [31:0] word_i,
  input  wire logic [31:0] max_frame_bytes_i,
  input  wire logic [31:0] sync_word_i,
  output fsc_result_t      res_o
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HUNT    = 2'd2;

  localparam logic [HdrIdxW:0] LastIdxLimit = (HdrIdxW + 1)'(HEADER_WORDS);
  localparam logic [32:0]      HeaderBytes  = 33'(HEADER_WORDS * 4);

  logic [1:0]            phase_q, phase_d;
  logic [HdrIdxW-1:0]    hidx_q, hidx_d;
  logic [31:0]           frame_size_q, frame_size_d;
  logic [31:0]           frame_seq_q, frame_seq_d;
  logic [31:0]           last_seq_q, last_seq_d;
  logic [WordsLeftW-1:0] words_left_q, words_left_d;
  logic [31:0]           frames_q, frames_d;
  logic [31:0]           seq_errs_q, seq_errs_d;
  logic [31:0]           size_errs_q, size_errs_d;

  logic [WordsLeftW-1:0] wl_dec;
  logic [32:0]           pay_span;
  logic [WordsLeftW-1:0] pay_words;
  logic                  last_hdr;
  logic                  finish;
  logic                  seq_bad;
  logic                  done, sizee, hunt;

  always_comb begin
    phase_d      = phase_q;
    hidx_d       = hidx_q;
    frame_size_d = frame_size_q;
    frame_seq_d  = frame_seq_q;
    words_left_d = words_left_q;
    size_errs_d  = size_errs_q;
    finish       = 1'b0;
    sizee        = 1'b0;
    hunt         = 1'b0;

    wl_dec    = words_left_q - WordsLeftW'(1);
    last_hdr  = ({1'b0, hidx_q} + (HdrIdxW + 1)'(1)) >= LastIdxLimit;
    pay_span  = 33'd0;
    pay_words = '0;

    case (phase_q)
      PH_HUNT: begin
        hunt = 1'b1;
        if (word_i == sync_word_i) begin
          phase_d = PH_HEADER;
          hidx_d  = '0;
        end
      end
      PH_PAYLOAD: begin
        words_left_d = wl_dec;
        if (wl_dec == '0) begin
          finish  = 1'b1;
          phase_d = PH_HEADER;
          hidx_d  = '0;
        end
      end
      default: begin
        if (hidx_q == HdrIdxW'(0)) begin
          frame_size_d = word_i;
        end else if (hidx_q == HdrIdxW'(1)) begin
          frame_seq_d = word_i;
        end
        // rounded-up payload word count past the header
        if ({1'b0, frame_size_d} > HeaderBytes) begin
          pay_span  = {1'b0, frame_size_d} - HeaderBytes + 33'd3;
          pay_words = pay_span[WordsLeftW+1:2];
        end
        if (last_hdr) begin
          hidx_d = '0;
          if (frame_size_d > max_frame_bytes_i) begin
            sizee       = 1'b1;
            hunt        = 1'b1;
            size_errs_d = size_errs_q + 32'd1;
            phase_d     = PH_HUNT;
          end else begin
            words_left_d = pay_words;
            if (pay_words == '0) begin
              finish  = 1'b1;
              phase_d = PH_HEADER;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end else begin
          hidx_d  = hidx_q + HdrIdxW'(1);
          phase_d = PH_HEADER;
        end
      end
    endcase

    // frame close: sequence check against previous id
    seq_bad    = finish && (frame_seq_d != (last_seq_q + 32'd1));
    done       = finish;
    last_seq_d = finish ? frame_seq_d : last_seq_q;
    frames_d   = finish ? frames_q + 32'd1 : frames_q;
    seq_errs_d = seq_bad ? seq_errs_q + 32'd1 : seq_errs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      hidx_q       <= '0;
      frame_size_q <= '0;
      frame_seq_q  <= '0;
      last_seq_q   <= '0;
      words_left_q <= '0;
      frames_q     <= '0;
      seq_errs_q   <= '0;
      size_errs_q  <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      hidx_q       <= hidx_d;
      frame_size_q <= frame_size_d;
      frame_seq_q  <= frame_seq_d;
      last_seq_q   <= last_seq_d;
      words_left_q <= words_left_d;
      frames_q     <= frames_d;
      seq_errs_q   <= seq_errs_d;
      size_errs_q  <= size_errs_d;
    end
  end

  always_comb begin
    res_o.frame_done       = done;
    res_o.seq_error        = seq_bad;
    res_o.size_error       = sizee;
    res_o.hunting          = hunt;
    res_o.frame_count      = frames_d;
    res_o.seq_error_count  = seq_errs_d;
    res_o.size_error_count = size_errs_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/frame_stream_checker.sv */
// Top level of the frame stream checker: input stage, config registers, result register.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / stream_word_i): one 32-bit stream word
//   per item. Frames are a header (size in bytes, sequence id, then ignored words)
//   followed by payload words, which are skipped.
// - Output channel (out_valid_o / out_stall_i / result fields): exactly one result
//   item per accepted word, in order: frame done, sequence error, size error,
//   hunting flag and the three wrapping totals including this word.
// - Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): index 0
//   is the frame size limit, index 1 the sync word. Always ready; write while idle.
// - Path from input accept to result valid: the input register, then the step logic
//   into the result register. Throughput: 1 item per cycle while the receiver does
//   not stall, set by the state update in fsc_core.
// - Receiver stall: the result register holds; one more item waits in the input
//   register, after which in_stall_o rises until the result is taken.
// - Reset: all frame state and totals clear, phase returns to header, limit and
//   sync word go to their defaults, both channels empty.
`default_nettype none

module frame_stream_checker
  import fsc_pkg::*;
#(
  parameter int unsigned HEADER_WORDS = HEADER_WORDS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input words
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [31:0]        stream_word_i,
  // results
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic               frame_done_o,
  output      logic               seq_error_o,
  output      logic               size_error_o,
  output      logic               hunting_o,
  output      logic [31:0]        frame_count_o,
  output      logic [31:0]        seq_error_count_o,
  output      logic [31:0]        size_error_count_o,
  // configuration writes
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_word_q;
  logic        out_valid_q, out_valid_d;
  fsc_result_t out_res_q;
  fsc_result_t step_res;
  logic [31:0] max_frame_bytes_q;
  logic [31:0] sync_word_q;

  logic in_acc;
  logic advance;   // input stage item moves into the result register

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign s1_valid_d  = in_acc || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  fsc_core #(
    .HEADER_WORDS (HEADER_WORDS)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (advance),
    .word_i            (s1_word_q),
    .max_frame_bytes_i (max_frame_bytes_q),
    .sync_word_i       (sync_word_q),
    .res_o             (step_res)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= stream_word_i;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_bytes_q <= MAX_FRAME_BYTES_RST;
      sync_word_q       <= SYNC_WORD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAX_FRAME_BYTES: max_frame_bytes_q <= cfg_data_i;
        CFG_SYNC_WORD:       sync_word_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign frame_done_o       = out_res_q.frame_done;
  assign seq_error_o        = out_res_q.seq_error;
  assign size_error_o       = out_res_q.size_error;
  assign hunting_o          = out_res_q.hunting;
  assign frame_count_o      = out_res_q.frame_count;
  assign seq_error_count_o  = out_res_q.seq_error_count;
  assign size_error_count_o = out_res_q.size_error_count;

endmodule

`default_nettype wire

/* hw/rtl/fsc_checker.sv */
// Port-level assertions for the frame stream checker, bound to the top level.
`default_nettype none

module fsc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        frame_done_o,
  input wire logic        seq_error_o,
  input wire logic        size_error_o,
  input wire logic        hunting_o,
  input wire logic [31:0] frame_count_o,
  input wire logic [31:0] seq_error_count_o,
  input wire logic [31:0] size_error_count_o
);

  logic        out_acc;
  logic [31:0] frames_seen_q;
  logic [31:0] size_errs_seen_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // totals carried from the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_seen_q    <= '0;
      size_errs_seen_q <= '0;
    end else if (out_acc) begin
      frames_seen_q    <= frame_count_o;
      size_errs_seen_q <= size_error_count_o;
    end
  end

  a_seq_err_needs_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seq_error_o |-> frame_done_o)
    else $error("sequence error without frame completion");

  a_size_err_hunts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && size_error_o |-> hunting_o && !frame_done_o)
    else $error("size error not flagged as hunting or also completing a frame");

  a_frame_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> frame_count_o == frames_seen_q + {31'd0, frame_done_o})
    else $error("frame total does not follow frame completions");

  a_size_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> size_error_count_o == size_errs_seen_q + {31'd0, size_error_o})
    else $error("size error total does not follow size errors");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_count_o)
      && $stable(seq_error_count_o) && $stable(hunting_o))
    else $error("stalled result changed");

endmodule

bind frame_stream_checker fsc_checker u_fsc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .frame_done_o       (frame_done_o),
  .seq_error_o        (seq_error_o),
  .size_error_o       (size_error_o),
  .hunting_o          (hunting_o),
  .frame_count_o      (frame_count_o),
  .seq_error_count_o  (seq_error_count_o),
  .size_error_count_o (size_error_count_o)
);

`default_nettype wire
